// ===== hdl/mi3_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mi3_pkg;

  localparam int DW    = 24;          // field width
  localparam int FB    = 16;          // fraction bits
  localparam int PW    = 2 * DW;      // element product
  localparam int CW    = 2 * DW + 1;  // cofactor
  localparam int DETW  = 3 * DW + 3;  // determinant
  localparam int QW    = DW + 1;      // quotient bits kept
  localparam int NW    = CW + 2 * FB; // scaled numerator magnitude
  localparam int TOPW  = NW - QW;     // numerator part above the kept quotient bits
  localparam int CMPW  = (TOPW > DETW) ? TOPW : DETW;
  localparam int LAT   = 2 + 2 + QW + 2;

  function automatic int nxt(input int i);
    return (i == 2) ? 0 : i + 1;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/mi3_cof.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mi3_cof import mi3_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [DW-1:0] m_i [9],
  output logic                 valid_o,
  output logic signed [CW-1:0] cof_o [9],
  output logic signed [DW-1:0] row0_o [3]
);

  logic                 v1_q, v2_q;
  logic signed [PW-1:0] pa_q [9];
  logic signed [PW-1:0] pb_q [9];
  logic signed [DW-1:0] r0_q [3];
  logic signed [CW-1:0] cof_q [9];
  logic signed [DW-1:0] r0b_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  // cofactor row k is the cross product of rows k+1 and k+2
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        pa_q[k*3+j] <= m_i[nxt(k)*3 + nxt(j)] * m_i[nxt(nxt(k))*3 + nxt(nxt(j))];
        pb_q[k*3+j] <= m_i[nxt(k)*3 + nxt(nxt(j))] * m_i[nxt(nxt(k))*3 + nxt(j)];
      end
    end
    for (int j = 0; j < 3; j++) begin
      r0_q[j]  <= m_i[j];
      r0b_q[j] <= r0_q[j];
    end
    for (int i = 0; i < 9; i++) begin
      cof_q[i] <= CW'(pa_q[i]) - CW'(pb_q[i]);
    end
  end

  assign valid_o = v2_q;
  assign cof_o   = cof_q;
  assign row0_o  = r0b_q;

endmodule
`default_nettype wire

// ===== hdl/mi3_det.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mi3_det import mi3_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [CW-1:0] cof_i [9],
  input  logic signed [DW-1:0] row0_i [3],
  output logic                 valid_o,
  output logic signed [CW-1:0] cof_o [9],
  output logic [DETW-1:0]      dmag_o,
  output logic                 dneg_o,
  output logic                 dzero_o
);

  logic                   v1_q, v2_q;
  logic signed [CW-1:0]   plo_q [3];
  logic signed [CW-1:0]   phi_q [3];
  logic signed [CW-1:0]   c1_q [9];
  logic signed [CW-1:0]   c2_q [9];
  logic signed [DETW-1:0] det;
  logic [DETW-1:0]        dmag_q;
  logic                   dneg_q, dzero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_comb begin
    det = '0;
    for (int j = 0; j < 3; j++) begin
      det = det + (DETW'(phi_q[j]) <<< DW) + DETW'(plo_q[j]);
    end
  end

  // split each row-0 cofactor into a low unsigned half and a high signed half
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      plo_q[j] <= row0_i[j] * $signed({1'b0, cof_i[j][DW-1:0]});
      phi_q[j] <= row0_i[j] * $signed(cof_i[j][CW-1:DW]);
    end
    c1_q    <= cof_i;
    c2_q    <= c1_q;
    dneg_q  <= det[DETW-1];
    dmag_q  <= det[DETW-1] ? DETW'(-det) : DETW'(det);
    dzero_q <= (det == '0);
  end

  assign valid_o = v2_q;
  assign cof_o   = c2_q;
  assign dmag_o  = dmag_q;
  assign dneg_o  = dneg_q;
  assign dzero_o = dzero_q;

endmodule
`default_nettype wire

// ===== hdl/mi3_div_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mi3_div_lane import mi3_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [CW-1:0] cof_i,
  input  logic [DETW-1:0]      dmag_i,
  input  logic                 dneg_i,
  input  logic                 dzero_i,
  output logic                 valid_o,
  output logic [DW-1:0]        res_o,
  output logic                 ovf_o,
  output logic                 sing_o
);

  localparam logic [QW-1:0] LIM = QW'(1) << (DW - 1);

  logic [CW-1:0]   nmag;
  logic [NW-1:0]   num;
  logic [CMPW-1:0] top_x;
  logic            big;

  logic [QW:0]     v_q;
  logic [DETW-1:0] rem_q [QW+1];
  logic [QW-1:0]   nlo_q [QW+1];
  logic [QW-1:0]   quo_q [QW+1];
  logic [DETW-1:0] d_q   [QW+1];
  logic [QW:0]     neg_q, big_q, zero_q;

  logic [DETW-1:0] rem_d [QW+1];
  logic [QW-1:0]   quo_d [QW+1];

  logic            vo_q, ovf_q, sing_q;
  logic [DW-1:0]   res_q;
  logic            sat;
  logic [QW-1:0]   qval;
  logic [DW-1:0]   res_d;

  assign nmag  = cof_i[CW-1] ? CW'(-cof_i) : CW'(cof_i);
  assign num   = {nmag, {(2*FB){1'b0}}};
  assign top_x = CMPW'(num[NW-1:QW]);
  assign big   = top_x >= CMPW'(dmag_i);

  // one restoring step per stage, quotient bit QW-s at stage s
  always_comb begin
    rem_d[0] = top_x[DETW-1:0];
    quo_d[0] = '0;
    for (int s = 1; s <= QW; s++) begin
      logic [DETW:0] remsh;
      logic [DETW:0] diff;
      logic          ge;
      remsh = {rem_q[s-1], nlo_q[s-1][QW-s]};
      diff  = remsh - {1'b0, d_q[s-1]};
      ge    = remsh >= {1'b0, d_q[s-1]};
      rem_d[s] = ge ? diff[DETW-1:0] : remsh[DETW-1:0];
      quo_d[s] = quo_q[s-1];
      quo_d[s][QW-s] = ge;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      vo_q <= 1'b0;
    end else begin
      v_q  <= {v_q[QW-1:0], valid_i};
      vo_q <= v_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= rem_d[0];
    quo_q[0]  <= quo_d[0];
    nlo_q[0]  <= num[QW-1:0];
    d_q[0]    <= dmag_i;
    neg_q[0]  <= cof_i[CW-1] ^ dneg_i;
    big_q[0]  <= big;
    zero_q[0] <= dzero_i;
    for (int s = 1; s <= QW; s++) begin
      rem_q[s]  <= rem_d[s];
      quo_q[s]  <= quo_d[s];
      nlo_q[s]  <= nlo_q[s-1];
      d_q[s]    <= d_q[s-1];
      neg_q[s]  <= neg_q[s-1];
      big_q[s]  <= big_q[s-1];
      zero_q[s] <= zero_q[s-1];
    end
    res_q  <= res_d;
    ovf_q  <= sat && !zero_q[QW];
    sing_q <= zero_q[QW];
  end

  // saturate to the signed field range, zero on a singular matrix
  always_comb begin
    if (neg_q[QW]) begin
      sat  = big_q[QW] || (quo_q[QW] > LIM);
      qval = sat ? LIM : quo_q[QW];
      res_d = DW'(-qval);
    end else begin
      sat  = big_q[QW] || (quo_q[QW] > (LIM - QW'(1)));
      qval = sat ? (LIM - QW'(1)) : quo_q[QW];
      res_d = qval[DW-1:0];
    end
    if (zero_q[QW]) begin
      res_d = '0;
    end
  end

  assign valid_o = vo_q;
  assign res_o   = res_q;
  assign ovf_o   = ovf_q;
  assign sing_o  = sing_q;

endmodule
`default_nettype wire

// ===== hdl/matrix3_inverse.sv =====
// channel   direction  handshake         payload
// command   in         start_i / busy_o  m00_i .. m22_i
// result    out        done_o            i00_o .. i22_o, singular_o, overflow_o
//
// One matrix may start every cycle; busy_o stays low.
// The pipeline has 2 cofactor stages, 2 determinant stages, one
// setup stage, one stage per quotient bit (25) and one saturation stage.
// Each result is shown for one cycle under done_o and cannot be held off.
// Reset clears only the valid bits; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module matrix3_inverse import mi3_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic signed [DW-1:0] m00_i, m01_i, m02_i,
  input  logic signed [DW-1:0] m10_i, m11_i, m12_i,
  input  logic signed [DW-1:0] m20_i, m21_i, m22_i,
  output logic                 done_o,
  output logic signed [DW-1:0] i00_o, i01_o, i02_o,
  output logic signed [DW-1:0] i10_o, i11_o, i12_o,
  output logic signed [DW-1:0] i20_o, i21_o, i22_o,
  output logic                 singular_o,
  output logic                 overflow_o
);

  logic signed [DW-1:0] m [9];
  logic                 cv, dv;
  logic signed [CW-1:0] cof_c [9];
  logic signed [CW-1:0] cof_d [9];
  logic signed [DW-1:0] row0 [3];
  logic [DETW-1:0]      dmag;
  logic                 dneg, dzero;
  logic [8:0]           lv, lovf, lsing;
  logic [DW-1:0]        res [9];

  assign busy_o = 1'b0;
  assign m[0] = m00_i; assign m[1] = m01_i; assign m[2] = m02_i;
  assign m[3] = m10_i; assign m[4] = m11_i; assign m[5] = m12_i;
  assign m[6] = m20_i; assign m[7] = m21_i; assign m[8] = m22_i;

  mi3_cof u_cof (
    .clk_i, .rst_ni, .valid_i(start_i && !busy_o), .m_i(m),
    .valid_o(cv), .cof_o(cof_c), .row0_o(row0)
  );

  mi3_det u_det (
    .clk_i, .rst_ni, .valid_i(cv), .cof_i(cof_c), .row0_i(row0),
    .valid_o(dv), .cof_o(cof_d), .dmag_o(dmag), .dneg_o(dneg), .dzero_o(dzero)
  );

  // element (r, c) of the inverse comes from cofactor row c, column r
  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      mi3_div_lane u_lane (
        .clk_i, .rst_ni, .valid_i(dv), .cof_i(cof_d[c*3+r]),
        .dmag_i(dmag), .dneg_i(dneg), .dzero_i(dzero),
        .valid_o(lv[r*3+c]), .res_o(res[r*3+c]),
        .ovf_o(lovf[r*3+c]), .sing_o(lsing[r*3+c])
      );
    end
  end

  assign done_o     = lv[0];
  assign singular_o = lsing[0];
  assign overflow_o = |lovf;
  assign i00_o = res[0]; assign i01_o = res[1]; assign i02_o = res[2];
  assign i10_o = res[3]; assign i11_o = res[4]; assign i12_o = res[5];
  assign i20_o = res[6]; assign i21_o = res[7]; assign i22_o = res[8];

  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lv == 9'h000) || (lv == 9'h1ff))
    else $error("divider lanes out of step");

  a_done_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LAT))
    else $error("result without a matching start");

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && singular_o) |-> (!overflow_o && i00_o == '0 && i11_o == '0 && i22_o == '0))
    else $error("singular result not cleared");

endmodule
`default_nettype wire

// ===== dv/tb_matrix3_inverse.sv =====
`timescale 1ns / 1ps
module tb_matrix3_inverse;
  import mi3_pkg::*;

  typedef logic [8:0][DW-1:0] mat_t;
  typedef struct packed {
    mat_t e;
    logic sing;
    logic ovf;
  } inv_t;
  typedef struct packed {
    logic chk;
    inv_t res;
  } plan_t;

  localparam int ONE = 1 << FB;
  localparam int MAXV = (1 << (DW - 1)) - 1;
  localparam int MINV = -(1 << (DW - 1));
  localparam int NDIR = 12;
  localparam int NRAND = 1300;
  localparam int TIMEOUT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o, done_o, singular_o, overflow_o;
  logic signed [DW-1:0] m_i [9];
  logic signed [DW-1:0] i_o [9];

  inv_t inv_expected_q[$];
  plan_t plan_q[$];
  int xfer_cnt = 0;
  int mismatches = 0;
  int cycles = 0;
  int gap_pct = 0;

  initial for (int k = 0; k < 9; k++) m_i[k] = '0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  matrix3_inverse uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .m00_i(m_i[0]), .m01_i(m_i[1]), .m02_i(m_i[2]),
    .m10_i(m_i[3]), .m11_i(m_i[4]), .m12_i(m_i[5]),
    .m20_i(m_i[6]), .m21_i(m_i[7]), .m22_i(m_i[8]),
    .done_o(done_o),
    .i00_o(i_o[0]), .i01_o(i_o[1]), .i02_o(i_o[2]),
    .i10_o(i_o[3]), .i11_o(i_o[4]), .i12_o(i_o[5]),
    .i20_o(i_o[6]), .i21_o(i_o[7]), .i22_o(i_o[8]),
    .singular_o(singular_o), .overflow_o(overflow_o)
  );

  // Adjugate inverse with exact wide cofactors, quotient truncated toward zero.
  function automatic inv_t adjugate_inverse(input mat_t m);
    logic signed [127:0] v[9];
    logic signed [127:0] cf[9];
    logic signed [127:0] det, num;
    logic [127:0] dmag, nmag, q, lim;
    int u, w;
    logic qneg;
    inv_t r;
    r = '0;
    lim = 128'd1 << (DW - 1);
    for (int k = 0; k < 9; k++) v[k] = {{(128 - DW){m[k][DW-1]}}, m[k]};
    for (int c = 0; c < 3; c++) begin
      u = (c + 1) % 3;
      w = (c + 2) % 3;
      cf[c*3+0] = v[u*3+1] * v[w*3+2] - v[u*3+2] * v[w*3+1];
      cf[c*3+1] = v[u*3+2] * v[w*3+0] - v[u*3+0] * v[w*3+2];
      cf[c*3+2] = v[u*3+0] * v[w*3+1] - v[u*3+1] * v[w*3+0];
    end
    det = v[0] * cf[0] + v[1] * cf[1] + v[2] * cf[2];
    if (det == 0) begin
      r.sing = 1'b1;
      return r;
    end
    dmag = (det < 0) ? -det : det;
    for (int row = 0; row < 3; row++)
      for (int col = 0; col < 3; col++) begin
        num = cf[col*3+row] <<< (2 * FB);
        nmag = (num < 0) ? -num : num;
        q = nmag / dmag;
        qneg = (num < 0) != (det < 0);
        if (qneg) begin
          if (q > lim) begin
            q = lim;
            r.ovf = 1'b1;
          end
          q = -q;
        end else if (q > lim - 1) begin
          q = lim - 1;
          r.ovf = 1'b1;
        end
        r.e[row*3+col] = q[DW-1:0];
      end
    return r;
  endfunction

  always @(posedge clk_i) begin
    plan_t p;
    inv_t got, want;
    mat_t cur;
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (start_i && !busy_o) begin
        for (int k = 0; k < 9; k++) cur[k] = m_i[k];
        p = plan_q.pop_front();
        inv_expected_q.push_back(p.chk ? p.res : adjugate_inverse(cur));
        xfer_cnt <= xfer_cnt + 1;
      end
      if (done_o) begin
        for (int k = 0; k < 9; k++) got.e[k] = i_o[k];
        got.sing = singular_o;
        got.ovf = overflow_o;
        if (inv_expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer at cycle %0d", cycles);
        end else begin
          want = inv_expected_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch at cycle %0d", cycles);
              for (int k = 0; k < 9; k++)
                if (got.e[k] !== want.e[k])
                  $display("  i%0d%0d exp %0d got %0d", k / 3, k % 3,
                           $signed(want.e[k]), $signed(got.e[k]));
              $display("  singular exp %b got %b, overflow exp %b got %b",
                       want.sing, got.sing, want.ovf, got.ovf);
            end
          end
        end
      end
    end
  end

  always @(posedge clk_i)
    if (cycles > TIMEOUT) begin
      $display("matrix3_inverse verification failed");
      $finish;
    end

  // called at a falling edge; returns at a falling edge after the transfer and any random idle gap
  task automatic send_matrix(input mat_t m, input logic chk, input inv_t res);
    int xfer_seen;
    plan_q.push_back('{chk: chk, res: res});
    xfer_seen = xfer_cnt;
    for (int k = 0; k < 9; k++) m_i[k] = m[k];
    start_i = 1'b1;
    do @(negedge clk_i); while (xfer_cnt == xfer_seen);
    // idle the sender at random, with start_i low and random data on the inputs
    while ($urandom_range(99) < gap_pct) begin
      start_i = 1'b0;
      for (int k = 0; k < 9; k++) m_i[k] = DW'($urandom());
      @(negedge clk_i);
    end
  endtask

  function automatic mat_t diag(input int a, input int b, input int c);
    mat_t m;
    m = '0;
    m[0] = a;
    m[4] = b;
    m[8] = c;
    return m;
  endfunction

  function automatic mat_t random_matrix();
    mat_t m;
    int mode, src;
    mode = $urandom_range(9);
    for (int k = 0; k < 9; k++) begin
      case (mode)
        0, 1, 2: m[k] = $urandom();
        3, 4, 5: m[k] = $urandom_range(4 * ONE) - 2 * ONE;
        9: m[k] = $urandom_range(510) - 255;
        default: m[k] = $urandom_range(ONE / 2) - ONE / 4;
      endcase
    end
    if (mode >= 3 && mode <= 7) begin
      // strengthen the diagonal for well-conditioned matrices
      m[0] = m[0] + ((mode & 1) ? 4 * ONE : -4 * ONE);
      m[4] = m[4] + 4 * ONE;
      m[8] = m[8] - 4 * ONE;
    end
    if (mode == 8) begin
      src = $urandom_range(2);
      for (int k = 0; k < 3; k++)
        case (src)
          0: m[6 + k] = m[k];
          1: m[3 + k] = 0;
          default: m[6 + k] = -m[3 + k];
        endcase
    end
    return m;
  endfunction

  initial begin
    mat_t dir_m[NDIR];
    logic dir_chk[NDIR];
    inv_t dir_res[NDIR];
    inv_t none;
    none = '0;
    for (int n = 0; n < NDIR; n++) begin
      dir_chk[n] = 1'b0;
      dir_res[n] = '0;
    end
    dir_m[0] = diag(ONE, ONE, ONE);
    dir_chk[0] = 1'b1;
    dir_res[0].e = diag(ONE, ONE, ONE);
    dir_m[1] = '0;
    dir_chk[1] = 1'b1;
    dir_res[1].sing = 1'b1;
    for (int k = 0; k < 9; k++) dir_m[2][k] = MAXV;
    dir_chk[2] = 1'b1;
    dir_res[2].sing = 1'b1;
    for (int k = 0; k < 9; k++) dir_m[3][k] = MINV;
    dir_chk[3] = 1'b1;
    dir_res[3].sing = 1'b1;
    dir_m[4] = diag(MINV, MINV, MINV);
    dir_chk[4] = 1'b1;
    dir_res[4].e = diag(-512, -512, -512);
    dir_m[5] = diag(1, 1, 1);
    dir_chk[5] = 1'b1;
    dir_res[5].e = diag(MAXV, MAXV, MAXV);
    dir_res[5].ovf = 1'b1;
    dir_m[6] = diag(-1, 1, 1);
    dir_chk[6] = 1'b1;
    dir_res[6].e = diag(MINV, MAXV, MAXV);
    dir_res[6].ovf = 1'b1;
    dir_m[7] = diag(MAXV, MAXV, MAXV);
    dir_m[8] = diag(2 * ONE, -4 * ONE, ONE / 2);
    dir_m[9] = diag(ONE, ONE, ONE);
    dir_m[9][1] = MAXV;
    dir_m[9][5] = MINV;
    for (int k = 0; k < 9; k++) dir_m[10][k] = (k % 2) ? MAXV : MINV;
    dir_m[11] = diag(3 * ONE, 5 * ONE, 7 * ONE);
    dir_m[11][3] = ONE;
    dir_m[11][7] = -ONE;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    gap_pct = 17;
    for (int n = 0; n < NDIR; n++) send_matrix(dir_m[n], dir_chk[n], dir_res[n]);
    for (int n = 0; n < NRAND; n++) begin
      if (n == NRAND / 3) gap_pct = 48;
      if (n == 2 * NRAND / 3) gap_pct = 0;
      send_matrix(random_matrix(), 1'b0, none);
    end
    start_i = 1'b0;
    while (inv_expected_q.size() != 0) @(negedge clk_i);
    repeat (LAT + 10) @(negedge clk_i);
    if (mismatches == 0)
      $display("matrix3_inverse verification clean");
    else
      $display("matrix3_inverse verification failed");
    $finish;
  end

endmodule
